[src/oal_pkg.sv]
// Shared types and codes for the ordered key/value list.
`default_nettype none
package oal_pkg;

  localparam int OAL_CAPACITY = 128;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 8;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 3;
  localparam int FIDX_W  = 7;
  localparam int CNTO_W  = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADIDX   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] entry_key;
    logic signed [DATA_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] out_key;
    logic signed [DATA_W-1:0] out_value;
    logic [FIDX_W-1:0]        found_index;
    logic [CNTO_W-1:0]        count_now;
  } rsp_t;

endpackage
`default_nettype wire

[src/ordered_array_list.sv]
// Ordered key/value list held in one memory, walked by a small sequencer.
// An insert moves the entries from the end down to the slot up by one; an insert at
// the end and an append move none. A remove moves the later entries down, a read
// fetches one entry, and a search walks from index 0 to the first matching value.
// The walk moves one entry per cycle; one command is worked at a time.
// Reset empties the list; entries are not cleared.
`default_nettype none
module ordered_array_list
  import oal_pkg::*;
#(
  parameter int CAPACITY = OAL_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int EW   = 2 * DATA_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_REM  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state;
  logic [CW-1:0]     count;
  req_t              req_r;
  logic [AW-1:0]     base;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     wptr;
  logic              issue;
  logic              pend;
  logic              pend_cap;
  logic [STAT_W-1:0] res_status;
  logic [DATA_W-1:0] res_key;
  logic [DATA_W-1:0] res_val;
  logic [FIDX_W-1:0] res_fidx;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [AW-1:0]   last_idx;
  logic            full;
  logic            match;
  logic            is_remove;

  assign req_ready = (state == S_IDLE);
  assign pos_ext   = CMPW'(req.position);
  assign cnt_ext   = CMPW'(count);
  assign last_idx  = AW'(count - CW'(1));
  assign full      = (count == CW'(CAPACITY));
  assign match     = (rd_data[DATA_W-1:0] == req_r.entry_value);
  assign is_remove = (req_r.command == CMD_REMOVE);

  // Write side of the memory: shifted entries, or the new entry at the end
  // of an insert walk.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wptr;
    wr_data = rd_data;
    unique case (state)
      S_INS: begin
        if (pend) begin
          wr_en = 1'b1;
        end else if (!issue) begin
          wr_en   = 1'b1;
          wr_addr = base;
          wr_data = {req_r.entry_key, req_r.entry_value};
        end
      end
      S_REM: begin
        if (pend && !pend_cap) begin
          wr_en = 1'b1;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      issue     <= 1'b0;
      pend      <= 1'b0;
      pend_cap  <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded instead.
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_r    <= req;
            res_key  <= '0;
            res_val  <= '0;
            res_fidx <= '0;
            pend     <= 1'b0;
            pend_cap <= 1'b0;
            unique case (req.command) inside
              CMD_INSERT, CMD_APPEND: begin
                if (full) begin
                  res_status <= ST_FULL;
                  issue      <= 1'b0;
                  state      <= S_DONE;
                end else if (req.command == CMD_INSERT && pos_ext > cnt_ext) begin
                  res_status <= ST_BADIDX;
                  issue      <= 1'b0;
                  state      <= S_DONE;
                end else begin
                  // For an insert, entries from the end down to the slot move up by one.
                  res_status <= ST_OK;
                  state      <= S_INS;
                  ptr        <= last_idx;
                  if (req.command == CMD_INSERT) begin
                    base  <= AW'(req.position);
                    issue <= (pos_ext < cnt_ext);
                  end else begin
                    base  <= AW'(count);
                    issue <= 1'b0;
                  end
                end
              end
              CMD_REMOVE, CMD_READ: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  issue      <= 1'b0;
                  state      <= S_DONE;
                end else if (pos_ext >= cnt_ext) begin
                  res_status <= ST_BADIDX;
                  issue      <= 1'b0;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_REM;
                  base       <= AW'(req.position);
                  ptr        <= AW'(req.position);
                  issue      <= 1'b1;
                end
              end
              CMD_SEARCH: begin
                if (count == '0) begin
                  res_status <= ST_NOTFOUND;
                  issue      <= 1'b0;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_SRCH;
                  ptr        <= '0;
                  issue      <= 1'b1;
                end
              end
              default: begin
                res_status <= ST_OK;
                issue      <= 1'b0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_INS: begin
          if (issue) begin
            pend <= 1'b1;
            wptr <= ptr + AW'(1);
            if (ptr == base) begin
              issue <= 1'b0;
            end else begin
              ptr <= ptr - AW'(1);
            end
          end else begin
            pend <= 1'b0;
          end
          if (!issue && !pend) begin
            count <= count + CW'(1);
            state <= S_DONE;
          end
        end
        S_REM: begin
          // The first beat read back is the entry itself; later ones move down.
          if (pend && pend_cap) begin
            res_key <= rd_data[EW-1:DATA_W];
            res_val <= rd_data[DATA_W-1:0];
          end
          if (issue) begin
            pend     <= 1'b1;
            pend_cap <= (ptr == base);
            wptr     <= ptr - AW'(1);
            if (!is_remove || ptr == last_idx) begin
              issue <= 1'b0;
            end else begin
              ptr <= ptr + AW'(1);
            end
          end else begin
            pend <= 1'b0;
          end
          if (!issue && !pend) begin
            if (is_remove) begin
              count <= count - CW'(1);
            end
            state <= S_DONE;
          end
        end
        S_SRCH: begin
          if (pend && match) begin
            res_fidx <= FIDX_W'(wptr);
            issue    <= 1'b0;
            pend     <= 1'b0;
            state    <= S_DONE;
          end else begin
            if (issue) begin
              pend <= 1'b1;
              wptr <= ptr;
              if (ptr == last_idx) begin
                issue <= 1'b0;
              end else begin
                ptr <= ptr + AW'(1);
              end
            end else begin
              pend <= 1'b0;
            end
            if (!issue && !pend) begin
              res_status <= ST_NOTFOUND;
              state      <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.status      <= res_status;
            rsp.out_key     <= res_key;
            rsp.out_value   <= res_val;
            rsp.found_index <= res_fidx;
            rsp.count_now   <= CNTO_W'(count);
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the ordered key/value list: directed corners, then random traffic.
`timescale 1ns / 1ps
module tb;
  import oal_pkg::*;

  localparam int STUCK_LIMIT = 3000;
  localparam int DRAIN_CYCLES = OAL_CAPACITY + 12;
  localparam logic [CMD_W-1:0] CMD_NOP5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_NOP6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NOP7 = 3'd7;

  class list_scoreboard;
    logic [DATA_W-1:0] keys [OAL_CAPACITY];
    logic [DATA_W-1:0] vals [OAL_CAPACITY];
    int unsigned count = 0;
    rsp_t expected_q[$];
    int unsigned mismatches = 0;

    // Applies one accepted command to the shadow list and queues its answer.
    function void note_command(req_t c);
      rsp_t r;
      int unsigned p;
      int unsigned i;
      bit hit;
      r = '0;
      r.status = ST_OK;
      p = 32'(c.position);
      hit = 0;
      case (c.command)
        CMD_INSERT: begin
          if (count >= OAL_CAPACITY) r.status = ST_FULL;
          else if (p > count) r.status = ST_BADIDX;
          else begin
            for (i = count; i > p; i--) begin
              keys[i] = keys[i-1];
              vals[i] = vals[i-1];
            end
            keys[p] = c.entry_key;
            vals[p] = c.entry_value;
            count++;
          end
        end
        CMD_APPEND: begin
          if (count >= OAL_CAPACITY) r.status = ST_FULL;
          else begin
            keys[count] = c.entry_key;
            vals[count] = c.entry_value;
            count++;
          end
        end
        CMD_REMOVE, CMD_READ: begin
          if (count == 0) r.status = ST_EMPTY;
          else if (p >= count) r.status = ST_BADIDX;
          else begin
            r.out_key = keys[p];
            r.out_value = vals[p];
            if (c.command == CMD_REMOVE) begin
              for (i = p; i + 1 < count; i++) begin
                keys[i] = keys[i+1];
                vals[i] = vals[i+1];
              end
              count--;
            end
          end
        end
        CMD_SEARCH: begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < count && !hit; i++) begin
            if (vals[i] == c.entry_value) begin
              hit = 1;
              r.status = ST_OK;
              r.found_index = i[FIDX_W-1:0];
            end
          end
        end
        default: ;
      endcase
      r.count_now = count[CNTO_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: response beat with nothing outstanding: %p", $realtime, got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.status !== exp_r.status || got.out_key !== exp_r.out_key ||
          got.out_value !== exp_r.out_value || got.found_index !== exp_r.found_index ||
          got.count_now !== exp_r.count_now) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: mismatch status %0d/%0d key %h/%h value %h/%h ", $realtime,
                 exp_r.status, got.status, exp_r.out_key, got.out_key,
                 exp_r.out_value, got.out_value);
          $display("index %0d/%0d count %0d/%0d (expected/actual)",
                   exp_r.found_index, got.found_index, exp_r.count_now, got.count_now);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  list_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned rsp_hold_request = 0;
  int unsigned stuck_cycles = 0;
  bit growing = 1;

  ordered_array_list uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    rsp_ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (rsp_hold_request > 0) begin
        hold_left = rsp_hold_request;
        rsp_hold_request = 0;
      end
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Handshake signals are stable at the falling edge, so beats are observed there.
  always @(negedge clk) begin
    if (rst === 1'b0) begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic req_t make_req(logic [CMD_W-1:0] cmd, int unsigned pos,
                                    logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
    req_t c;
    c.command = cmd;
    c.position = pos[POS_W-1:0];
    c.entry_key = k;
    c.entry_value = v;
    return c;
  endfunction

  // A small pool of values makes duplicate matches likely for search.
  function automatic logic [DATA_W-1:0] random_word();
    if ($urandom_range(9) < 3) return $urandom_range(6) - 3;
    return $urandom;
  endfunction

  function automatic req_t next_random_command();
    req_t c;
    int unsigned roll;
    int unsigned cnt;
    cnt = sb.count;
    c.entry_key = random_word();
    c.entry_value = random_word();
    c.position = POS_W'($urandom_range(255, 0));
    // Sweep the fill level between empty and full, lingering a little at each end.
    if (cnt == OAL_CAPACITY && $urandom_range(5) == 0) growing = 0;
    if (cnt == 0 && $urandom_range(3) == 0) growing = 1;
    roll = $urandom_range(99);
    if (roll < 4) c.command = CMD_W'($urandom_range(CMD_NOP7, CMD_NOP5));
    else if (roll < 14) c.command = CMD_SEARCH;
    else if (roll < 26) c.command = CMD_READ;
    else if (growing)
      c.command = (roll < 36) ? CMD_REMOVE : (roll < 68) ? CMD_INSERT : CMD_APPEND;
    else c.command = (roll < 90) ? CMD_REMOVE : (roll < 95) ? CMD_INSERT : CMD_APPEND;
    if ($urandom_range(9) != 0) begin
      case (c.command)
        CMD_INSERT: c.position = POS_W'($urandom_range(cnt, 0));
        CMD_REMOVE, CMD_READ: if (cnt > 0) c.position = POS_W'($urandom_range(cnt - 1, 0));
        default: ;
      endcase
    end else if ($urandom_range(2) == 0) begin
      c.position = cnt[POS_W-1:0];
    end
    if (c.command == CMD_SEARCH && cnt > 0 && $urandom_range(9) < 6)
      c.entry_value = sb.vals[$urandom_range(cnt - 1, 0)];
    return c;
  endfunction

  // Called at a rising edge; returns at the edge where the beat is accepted.
  task automatic send_command(input req_t c);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req <= c;
    req_valid <= 1'b1;
    @(negedge clk);
    while (!req_ready) @(negedge clk);
    sb.note_command(c);
    @(posedge clk);
  endtask

  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned idle_plan [5];
    int unsigned stall_plan [5];
    int ph;
    int n;
    idle_plan = '{0, 47, 0, 22, 0};
    stall_plan = '{0, 0, 47, 22, 0};
    sb = new();
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty-list cases and out-of-range inserts.
    send_command(make_req(CMD_SEARCH, 0, 32'h0, 32'h0));
    send_command(make_req(CMD_REMOVE, 0, 32'h0, 32'h0));
    send_command(make_req(CMD_READ, 0, 32'h0, 32'h0));
    send_command(make_req(CMD_INSERT, 1, 32'h1, 32'h1));
    send_command(make_req(CMD_INSERT, 255, 32'hFFFFFFFF, 32'hFFFFFFFF));
    // Build a short list with extreme keys and values at the front, middle and end.
    send_command(make_req(CMD_INSERT, 0, 32'h7FFFFFFF, 32'h80000000));
    send_command(make_req(CMD_APPEND, 0, 32'h80000000, 32'h7FFFFFFF));
    send_command(make_req(CMD_INSERT, 2, 32'hFFFFFFFF, 32'hFFFFFFFF));
    send_command(make_req(CMD_INSERT, 1, 32'h0, 32'h0));
    send_command(make_req(CMD_APPEND, 128, 32'h55555555, 32'hAAAAAAAA));
    send_command(make_req(CMD_READ, 0, 32'h0, 32'h0));
    send_command(make_req(CMD_READ, 4, 32'h0, 32'h0));
    send_command(make_req(CMD_READ, 5, 32'h0, 32'h0));
    send_command(make_req(CMD_READ, 128, 32'h0, 32'h0));
    send_command(make_req(CMD_SEARCH, 0, 32'h0, 32'hFFFFFFFF));
    send_command(make_req(CMD_SEARCH, 0, 32'h0, 32'h00003039));
    // A duplicate value: search must report the first match.
    send_command(make_req(CMD_APPEND, 0, 32'h12345678, 32'h0));
    send_command(make_req(CMD_SEARCH, 0, 32'h0, 32'h0));
    send_command(make_req(CMD_REMOVE, 6, 32'h0, 32'h0));
    send_command(make_req(CMD_REMOVE, 0, 32'h0, 32'h0));
    send_command(make_req(CMD_REMOVE, 4, 32'h0, 32'h0));
    send_command(make_req(CMD_REMOVE, 1, 32'h0, 32'h0));
    send_command(make_req(CMD_NOP5, 255, 32'hFFFFFFFF, 32'hFFFFFFFF));
    send_command(make_req(CMD_NOP6, 0, 32'h0, 32'h0));
    send_command(make_req(CMD_NOP7, 128, 32'h80000000, 32'h7FFFFFFF));
    wait_for_drain();

    // Back-pressure: the receiver holds off while the sender keeps offering beats.
    rsp_hold_request = 300;
    repeat (20) send_command(next_random_command());
    wait_for_drain();

    for (ph = 0; ph < 5; ph++) begin
      send_idle_pct = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      for (n = 0; n < 220; n++) send_command(next_random_command());
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
